### hdl/line_tile_intersection_core_macros.svh
// Assertion macros for the line and tile intersection core.
// Taken in by line_tile_intersection_core, which checks its own pipeline control.
`ifndef LINE_TILE_INTERSECTION_CORE_MACROS_SVH
`define LINE_TILE_INTERSECTION_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTILE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LTILE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ltile_pkg.sv
// Shared constants, types and helper functions of the line and tile intersection core.
// Used by ltile_div, line_tile_intersection_core and the testbench; depends on nothing else.
package ltile_pkg;

   localparam int TILE_BITS = 7;
   localparam int TILE_SIZE = 1 << TILE_BITS;

   localparam int PT_W  = 15;
   localparam int DIR_W = 16;
   localparam int OUT_W = 17;

   localparam int TX_W  = 16 - TILE_BITS;
   localparam int OFS_W = TILE_BITS + 1;
   localparam int NUM_W = TILE_BITS + 19;
   localparam int DEN_W = DIR_W + 1;
   localparam int Q_W   = NUM_W + 1;
   localparam int CW    = Q_W + 1;

   // One register for the magnitudes, one per quotient bit, one for the sign.
   localparam int DIV_LAT = NUM_W + 2;
   localparam int NUM_DIV = 7;

   localparam int IN_DATA_W  = ((2 * PT_W + 2 * DIR_W + 7) / 8) * 8;
   localparam int OUT_DATA_W = ((6 * OUT_W + 7) / 8) * 8;
   localparam int OUT_PAD_W  = OUT_DATA_W - 6 * OUT_W;

   localparam int NO_POINT = -4 * TILE_SIZE;
   localparam int FAR_OFS  = 4 * TILE_SIZE;

   // Divider slots.
   localparam int DIV_LEFT   = 0;
   localparam int DIV_RIGHT  = 1;
   localparam int DIV_TOP    = 2;
   localparam int DIV_BOTTOM = 3;
   localparam int DIV_ANTI_X = 4;
   localparam int DIV_ANTI_Y = 5;
   localparam int DIV_MAIN   = 6;

   typedef logic        [PT_W-1:0]  pt_type;
   typedef logic signed [DIR_W-1:0] dir_type;
   typedef logic signed [TX_W-1:0]  tidx_type;
   typedef logic        [OFS_W-1:0] ofs_type;
   typedef logic signed [NUM_W-1:0] num_type;
   typedef logic signed [DEN_W-1:0] den_type;
   typedef logic signed [Q_W-1:0]   quo_type;
   typedef logic signed [CW-1:0]    coord_type;
   typedef logic signed [OUT_W-1:0] out_type;

   typedef struct packed {
      pt_type   x;
      pt_type   y;
      dir_type  dx;
      dir_type  dy;
      tidx_type tx;
      tidx_type ty;
      ofs_type  ox;
      ofs_type  oy;
   } front_type;

   typedef struct packed {
      pt_type   x;
      pt_type   y;
      tidx_type tx;
      tidx_type ty;
      logic     dx_neg;
      logic     dy_neg;
      logic     dx_z;
      logic     dy_z;
      logic     sum_z;
      logic     diff_z;
   } side_type;

   typedef struct packed {
      coord_type ily;
      coord_type iry;
      coord_type itx;
      coord_type ibx;
      logic      hit_l;
      logic      hit_r;
      logic      hit_t;
      logic      hit_b;
      logic      on_l;
      logic      on_r;
      logic      on_t;
      logic      on_b;
      logic      anti_in;
      logic      main_in;
      quo_type   qax;
      quo_type   qay;
      quo_type   qm;
      tidx_type  tx;
      tidx_type  ty;
      logic      dx_neg;
      logic      dy_neg;
      logic      sum_z;
      logic      diff_z;
   } mid_type;

   typedef struct packed {
      out_type entry_x;
      out_type entry_y;
      out_type exit_x;
      out_type exit_y;
      out_type split_x;
      out_type split_y;
      logic    hit;
   } res_type;

   function automatic logic on_tile(input coord_type c, input tidx_type t);
      return (c >>> TILE_BITS) == coord_type'(t);
   endfunction

   // A point on the shared edge of two tiles counts for both of them.
   function automatic logic edge_hit(input coord_type c, input tidx_type t);
      return on_tile(c, t) || on_tile(c - coord_type'(1), t);
   endfunction

   function automatic coord_type corner(input tidx_type t);
      return coord_type'(t) <<< TILE_BITS;
   endfunction

endpackage

### hdl/line_tile_intersection_core.sv
// Top level of the line and tile intersection core: tile lookup, edge and diagonal tests.
// Depends on ltile_pkg, ltile_div and line_tile_intersection_core_macros.svh.
//
//   channel | dir | word contents
//   req_*   | in  | point and direction of one line
//   rsp_*   | out | entry, exit and diagonal crossing of that line
//
// One word enters per cycle while req_tready is high; a word passes stage 1, stage 2, stage 3,
// the seven bit-per-stage dividers that run side by side, stage 4, stage 5 and the output register.
// Reset is synchronous and clears only valid bits; no clearing pass is needed.
// The output register is backed by a skid register; the pipeline stops only when both are
// full, and then holds every stage in place.
`include "line_tile_intersection_core_macros.svh"

module line_tile_intersection_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // point_x, point_y, dir_x, dir_y from bit 0 up, zero filled
   input  logic [ltile_pkg::IN_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // entry_x, entry_y, exit_x, exit_y, split_x, split_y from bit 0 up, zero filled
   output logic [ltile_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   // crosses_split
   output logic [0:0]                          rsp_tuser
);

   localparam int PT_W  = ltile_pkg::PT_W;
   localparam int DIR_W = ltile_pkg::DIR_W;
   localparam int TB    = ltile_pkg::TILE_BITS;
   localparam int LAT   = ltile_pkg::DIV_LAT;
   localparam int ND    = ltile_pkg::NUM_DIV;

   logic pipe_en;

   ltile_pkg::res_type out_ff, skid_ff;
   logic               out_v_ff, skid_v_ff;

   // ---------------- stage 1: tile and offset, backward step ----------------
   ltile_pkg::pt_type    in_x, in_y;
   ltile_pkg::dir_type   in_dx, in_dy;
   ltile_pkg::tidx_type  tx_raw, ty_raw;
   ltile_pkg::ofs_type   ox_raw, oy_raw;
   ltile_pkg::front_type s1_in, s1_ff, s2_ff;
   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   assign in_x  = req_tdata[PT_W-1:0];
   assign in_y  = req_tdata[2*PT_W-1:PT_W];
   assign in_dx = ltile_pkg::dir_type'(req_tdata[2*PT_W+DIR_W-1:2*PT_W]);
   assign in_dy = ltile_pkg::dir_type'(req_tdata[2*PT_W+2*DIR_W-1:2*PT_W+DIR_W]);

   assign tx_raw = ltile_pkg::tidx_type'(in_x >> TB);
   assign ty_raw = ltile_pkg::tidx_type'(in_y >> TB);
   assign ox_raw = ltile_pkg::ofs_type'(in_x[TB-1:0]);
   assign oy_raw = ltile_pkg::ofs_type'(in_y[TB-1:0]);

   always_comb begin
      s1_in.x  = in_x;
      s1_in.y  = in_y;
      s1_in.dx = in_dx;
      s1_in.dy = in_dy;
      s1_in.tx = tx_raw;
      s1_in.ty = ty_raw;
      s1_in.ox = ox_raw;
      s1_in.oy = oy_raw;
      // On a low edge and moving backward: the line belongs to the tile behind.
      if (ox_raw == '0 && in_dx[DIR_W-1]) begin
         s1_in.tx = tx_raw - ltile_pkg::tidx_type'(1);
         s1_in.ox = ltile_pkg::ofs_type'(ltile_pkg::TILE_SIZE);
      end
      if (oy_raw == '0 && in_dy[DIR_W-1]) begin
         s1_in.ty = ty_raw - ltile_pkg::tidx_type'(1);
         s1_in.oy = ltile_pkg::ofs_type'(ltile_pkg::TILE_SIZE);
      end
   end

   // ---------------- stage 2: products ----------------
   ltile_pkg::ofs_type rx_ofs, ry_ofs;
   ltile_pkg::num_type n_l_in, n_r_in, n_t_in, n_b_in;
   ltile_pkg::num_type n_l_ff, n_r_ff, n_t_ff, n_b_ff;

   assign rx_ofs = ltile_pkg::ofs_type'(ltile_pkg::TILE_SIZE) - s1_ff.ox;
   assign ry_ofs = ltile_pkg::ofs_type'(ltile_pkg::TILE_SIZE) - s1_ff.oy;

   assign n_l_in = ltile_pkg::num_type'(s1_ff.ox) * ltile_pkg::num_type'(s1_ff.dy);
   assign n_r_in = ltile_pkg::num_type'(rx_ofs)   * ltile_pkg::num_type'(s1_ff.dy);
   assign n_t_in = ltile_pkg::num_type'(s1_ff.oy) * ltile_pkg::num_type'(s1_ff.dx);
   assign n_b_in = ltile_pkg::num_type'(ry_ofs)   * ltile_pkg::num_type'(s1_ff.dx);

   // ---------------- stage 3: dividends and divisors ----------------
   ltile_pkg::num_type  num3_in [ND];
   ltile_pkg::num_type  num3_ff [ND];
   ltile_pkg::den_type  den3_in [ND];
   ltile_pkg::den_type  den3_ff [ND];
   ltile_pkg::den_type  d_x, d_y, d_sum, d_diff;
   ltile_pkg::den_type  d_x_nz, d_y_nz, d_sum_nz, d_diff_nz;
   ltile_pkg::side_type side3_in, side3_ff;

   assign d_x    = ltile_pkg::den_type'(s2_ff.dx);
   assign d_y    = ltile_pkg::den_type'(s2_ff.dy);
   assign d_sum  = d_x + d_y;
   assign d_diff = d_x - d_y;

   // A zero divisor is replaced by one; its quotient is discarded later.
   assign d_x_nz    = (d_x == '0)    ? ltile_pkg::den_type'(1) : d_x;
   assign d_y_nz    = (d_y == '0)    ? ltile_pkg::den_type'(1) : d_y;
   assign d_sum_nz  = (d_sum == '0)  ? ltile_pkg::den_type'(1) : d_sum;
   assign d_diff_nz = (d_diff == '0) ? ltile_pkg::den_type'(1) : d_diff;

   always_comb begin
      num3_in[ltile_pkg::DIV_LEFT]   = n_l_ff;
      num3_in[ltile_pkg::DIV_RIGHT]  = n_r_ff;
      num3_in[ltile_pkg::DIV_TOP]    = n_t_ff;
      num3_in[ltile_pkg::DIV_BOTTOM] = n_b_ff;
      num3_in[ltile_pkg::DIV_ANTI_X] = n_b_ff + n_l_ff;
      num3_in[ltile_pkg::DIV_ANTI_Y] = n_r_ff + n_t_ff;
      num3_in[ltile_pkg::DIV_MAIN]   = n_t_ff - n_l_ff;

      den3_in[ltile_pkg::DIV_LEFT]   = d_x_nz;
      den3_in[ltile_pkg::DIV_RIGHT]  = d_x_nz;
      den3_in[ltile_pkg::DIV_TOP]    = d_y_nz;
      den3_in[ltile_pkg::DIV_BOTTOM] = d_y_nz;
      den3_in[ltile_pkg::DIV_ANTI_X] = d_sum_nz;
      den3_in[ltile_pkg::DIV_ANTI_Y] = d_sum_nz;
      den3_in[ltile_pkg::DIV_MAIN]   = d_diff_nz;

      side3_in.x      = s2_ff.x;
      side3_in.y      = s2_ff.y;
      side3_in.tx     = s2_ff.tx;
      side3_in.ty     = s2_ff.ty;
      side3_in.dx_neg = s2_ff.dx[DIR_W-1];
      side3_in.dy_neg = s2_ff.dy[DIR_W-1];
      side3_in.dx_z   = (d_x == '0);
      side3_in.dy_z   = (d_y == '0);
      side3_in.sum_z  = (d_sum == '0);
      side3_in.diff_z = (d_diff == '0);
   end

   // ---------------- dividers and the side data that travels beside them ----------------
   ltile_pkg::quo_type  quo [ND];
   ltile_pkg::side_type side_ff [LAT];
   logic [LAT-1:0]      vdiv_ff;

   for (genvar g = 0; g < ND; g++) begin : g_div
      ltile_div u_div (
         .clock (clock),
         .en    (pipe_en),
         .num_i (num3_ff[g]),
         .den_i (den3_ff[g]),
         .quo_o (quo[g])
      );
   end

   // ---------------- stage 4: edge crossings and tile tests ----------------
   ltile_pkg::side_type sd;
   ltile_pkg::coord_type xc, yc, far_c;
   ltile_pkg::mid_type  m4_in, m4_ff;

   assign sd    = side_ff[LAT-1];
   assign xc    = ltile_pkg::coord_type'(sd.x);
   assign yc    = ltile_pkg::coord_type'(sd.y);
   assign far_c = ltile_pkg::coord_type'(ltile_pkg::FAR_OFS);

   always_comb begin
      m4_in.ily = sd.dx_z ? yc - far_c
                          : yc - ltile_pkg::coord_type'(quo[ltile_pkg::DIV_LEFT]);
      m4_in.iry = sd.dx_z ? yc - far_c
                          : yc + ltile_pkg::coord_type'(quo[ltile_pkg::DIV_RIGHT]);
      m4_in.itx = sd.dy_z ? xc - far_c
                          : xc - ltile_pkg::coord_type'(quo[ltile_pkg::DIV_TOP]);
      m4_in.ibx = sd.dy_z ? xc - far_c
                          : xc + ltile_pkg::coord_type'(quo[ltile_pkg::DIV_BOTTOM]);

      m4_in.hit_l = ltile_pkg::edge_hit(m4_in.ily, sd.ty);
      m4_in.hit_r = ltile_pkg::edge_hit(m4_in.iry, sd.ty);
      m4_in.hit_t = ltile_pkg::edge_hit(m4_in.itx, sd.tx);
      m4_in.hit_b = ltile_pkg::edge_hit(m4_in.ibx, sd.tx);
      m4_in.on_l  = ltile_pkg::on_tile(m4_in.ily, sd.ty);
      m4_in.on_r  = ltile_pkg::on_tile(m4_in.iry, sd.ty);
      m4_in.on_t  = ltile_pkg::on_tile(m4_in.itx, sd.tx);
      m4_in.on_b  = ltile_pkg::on_tile(m4_in.ibx, sd.tx);

      m4_in.qax = quo[ltile_pkg::DIV_ANTI_X];
      m4_in.qay = quo[ltile_pkg::DIV_ANTI_Y];
      m4_in.qm  = quo[ltile_pkg::DIV_MAIN];

      // Corner plus q stays in the tile exactly when q lies in [0, TILE_SIZE).
      m4_in.anti_in = !m4_in.qax[ltile_pkg::Q_W-1] &&
                      (m4_in.qax < ltile_pkg::quo_type'(ltile_pkg::TILE_SIZE)) &&
                      !m4_in.qay[ltile_pkg::Q_W-1] &&
                      (m4_in.qay < ltile_pkg::quo_type'(ltile_pkg::TILE_SIZE));
      m4_in.main_in = !m4_in.qm[ltile_pkg::Q_W-1] &&
                      (m4_in.qm < ltile_pkg::quo_type'(ltile_pkg::TILE_SIZE));

      m4_in.tx     = sd.tx;
      m4_in.ty     = sd.ty;
      m4_in.dx_neg = sd.dx_neg;
      m4_in.dy_neg = sd.dy_neg;
      m4_in.sum_z  = sd.sum_z;
      m4_in.diff_z = sd.diff_z;
   end

   // ---------------- stage 5: entry, exit and diagonal selection ----------------
   ltile_pkg::res_type   r5_in, r5_ff;
   ltile_pkg::coord_type cx_lo, cx_hi, cy_lo, cy_hi;
   ltile_pkg::out_type   no_pt;

   assign cx_lo = ltile_pkg::corner(m4_ff.tx);
   assign cy_lo = ltile_pkg::corner(m4_ff.ty);
   assign cx_hi = cx_lo + ltile_pkg::coord_type'(ltile_pkg::TILE_SIZE);
   assign cy_hi = cy_lo + ltile_pkg::coord_type'(ltile_pkg::TILE_SIZE);
   assign no_pt = ltile_pkg::out_type'(ltile_pkg::NO_POINT);

   always_comb begin
      logic main_only;
      logic anti_only;
      logic anti_hit;
      logic main_hit;

      r5_in.entry_x = no_pt;
      r5_in.entry_y = no_pt;
      r5_in.exit_x  = no_pt;
      r5_in.exit_y  = no_pt;
      r5_in.split_x = '0;
      r5_in.split_y = '0;
      r5_in.hit     = 1'b0;

      // Later edges override earlier ones, so top and bottom win over left and right.
      if (m4_ff.hit_l) begin
         if (!m4_ff.dx_neg) begin
            r5_in.entry_x = ltile_pkg::out_type'(cx_lo);
            r5_in.entry_y = ltile_pkg::out_type'(m4_ff.ily);
         end else begin
            r5_in.exit_x = ltile_pkg::out_type'(cx_lo);
            r5_in.exit_y = ltile_pkg::out_type'(m4_ff.ily);
         end
      end
      if (m4_ff.hit_r) begin
         if (!m4_ff.dx_neg) begin
            r5_in.exit_x = ltile_pkg::out_type'(cx_hi);
            r5_in.exit_y = ltile_pkg::out_type'(m4_ff.iry);
         end else begin
            r5_in.entry_x = ltile_pkg::out_type'(cx_hi);
            r5_in.entry_y = ltile_pkg::out_type'(m4_ff.iry);
         end
      end
      if (m4_ff.hit_t) begin
         if (!m4_ff.dy_neg) begin
            r5_in.entry_x = ltile_pkg::out_type'(m4_ff.itx);
            r5_in.entry_y = ltile_pkg::out_type'(cy_lo);
         end else begin
            r5_in.exit_x = ltile_pkg::out_type'(m4_ff.itx);
            r5_in.exit_y = ltile_pkg::out_type'(cy_lo);
         end
      end
      if (m4_ff.hit_b) begin
         if (!m4_ff.dy_neg) begin
            r5_in.exit_x = ltile_pkg::out_type'(m4_ff.ibx);
            r5_in.exit_y = ltile_pkg::out_type'(cy_hi);
         end else begin
            r5_in.entry_x = ltile_pkg::out_type'(m4_ff.ibx);
            r5_in.entry_y = ltile_pkg::out_type'(cy_hi);
         end
      end

      // Only one diagonal crossing is ever reported: the anti-diagonal is tried first.
      main_only = (m4_ff.on_t == m4_ff.on_l) && (m4_ff.on_b == m4_ff.on_r);
      anti_only = !main_only && (m4_ff.on_b == m4_ff.on_l) && (m4_ff.on_t == m4_ff.on_r);
      anti_hit  = !main_only && !m4_ff.sum_z && m4_ff.anti_in;
      main_hit  = !anti_hit && !anti_only && !m4_ff.diff_z && m4_ff.main_in;

      if (anti_hit) begin
         r5_in.split_x = ltile_pkg::out_type'(cx_lo + ltile_pkg::coord_type'(m4_ff.qax));
         r5_in.split_y = ltile_pkg::out_type'(cy_lo + ltile_pkg::coord_type'(m4_ff.qay));
         r5_in.hit     = 1'b1;
      end else if (main_hit) begin
         r5_in.split_x = ltile_pkg::out_type'(cx_lo + ltile_pkg::coord_type'(m4_ff.qm));
         r5_in.split_y = ltile_pkg::out_type'(cy_lo + ltile_pkg::coord_type'(m4_ff.qm));
         r5_in.hit     = 1'b1;
      end
   end

   // ---------------- pipeline registers ----------------
   assign pipe_en    = !skid_v_ff;
   assign req_tready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         vdiv_ff <= '0;
         v4_ff   <= 1'b0;
         v5_ff   <= 1'b0;
      end else if (pipe_en) begin
         v1_ff   <= req_tvalid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         vdiv_ff <= {vdiv_ff[LAT-2:0], v3_ff};
         v4_ff   <= vdiv_ff[LAT-1];
         v5_ff   <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_ff    <= s1_in;
         s2_ff    <= s1_ff;
         n_l_ff   <= n_l_in;
         n_r_ff   <= n_r_in;
         n_t_ff   <= n_t_in;
         n_b_ff   <= n_b_in;
         num3_ff  <= num3_in;
         den3_ff  <= den3_in;
         side3_ff <= side3_in;
         side_ff[0] <= side3_ff;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         m4_ff <= m4_in;
         r5_ff <= r5_in;
      end
   end

   // ---------------- output register with skid ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= v5_ff;
         end
      end else if (v5_ff && !skid_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_ff <= skid_v_ff ? skid_ff : r5_ff;
      end else if (v5_ff && !skid_v_ff) begin
         skid_ff <= r5_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{ltile_pkg::OUT_PAD_W{1'b0}},
                        out_ff.split_y, out_ff.split_x,
                        out_ff.exit_y,  out_ff.exit_x,
                        out_ff.entry_y, out_ff.entry_x};
   assign rsp_tuser  = out_ff.hit;

   // ---------------- checks ----------------
   `LTILE_ASSERT_NOW(a_skid_needs_out, clock, reset, skid_v_ff, out_v_ff, "skid word without output word")
   `LTILE_ASSERT_NEXT(a_skid_holds, clock, reset, skid_v_ff && !rsp_tready, skid_v_ff, "skid word lost")
   `LTILE_ASSERT_NEXT(a_pipe_frozen, clock, reset, skid_v_ff, $stable(v5_ff) && $stable(vdiv_ff), "pipeline moved while full")
   `LTILE_ASSERT_NOW(a_split_zero, clock, reset, out_v_ff && !out_ff.hit, out_ff.split_x == '0 && out_ff.split_y == '0, "split point set without crossing")

endmodule

### hdl/ltile_div.sv
// Pipelined signed divider, quotient truncated toward zero, one quotient bit per stage.
// Depends on ltile_pkg for the operand widths; the divisor must not be zero.
module ltile_div (
   input  logic                clock,
   input  logic                en,
   input  ltile_pkg::num_type  num_i,
   input  ltile_pkg::den_type  den_i,
   output ltile_pkg::quo_type  quo_o
);

   localparam int W = ltile_pkg::NUM_W;
   localparam int D = ltile_pkg::DEN_W;

   logic [D-1:0] rem_ff [0:W];
   logic [W-1:0] nq_ff  [0:W];
   logic [D-1:0] dm_ff  [0:W];
   logic         neg_ff [0:W];
   ltile_pkg::quo_type quo_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         nq_ff[0]  <= num_i[W-1] ? W'(-num_i) : W'(num_i);
         dm_ff[0]  <= den_i[D-1] ? D'(-den_i) : D'(den_i);
         neg_ff[0] <= num_i[W-1] ^ den_i[D-1];
      end
   end

   // Each stage brings down the next dividend bit and yields one quotient bit;
   // the dividend register fills up with quotient bits from the bottom.
   for (genvar k = 0; k < W; k++) begin : g_step
      logic [D:0]   shifted;
      logic [D:0]   diff;
      logic         ge;

      assign shifted = {rem_ff[k], nq_ff[k][W-1]};
      assign diff    = shifted - {1'b0, dm_ff[k]};
      assign ge      = shifted >= {1'b0, dm_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? diff[D-1:0] : shifted[D-1:0];
            nq_ff[k+1]  <= {nq_ff[k][W-2:0], ge};
            dm_ff[k+1]  <= dm_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= neg_ff[W] ? -ltile_pkg::quo_type'({1'b0, nq_ff[W]})
                             :  ltile_pkg::quo_type'({1'b0, nq_ff[W]});
      end
   end

   assign quo_o = quo_ff;

endmodule

### tb/line_tile_intersection_core_tb.sv
// Self-checking testbench for the line and tile intersection core.
// Depends on ltile_pkg and line_tile_intersection_core; predicts each result in plain integers.
`timescale 1ns / 1ps

module line_tile_intersection_core_tb;

   localparam int TB_TILE_BITS = ltile_pkg::TILE_BITS;
   localparam int TB_TILE_SIZE = 1 << TB_TILE_BITS;
   localparam int LATENCY = TB_TILE_BITS + 26;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [16:0] entry_x;
      logic [16:0] entry_y;
      logic [16:0] exit_x;
      logic [16:0] exit_y;
      logic [16:0] split_x;
      logic [16:0] split_y;
      logic        crosses;
   } crossing_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [ltile_pkg::IN_DATA_W-1:0]  req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [ltile_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic [0:0]                       rsp_tuser;

   crossing_type expected_crossings[$];
   int           error_count = 0;
   longint       cycle_count = 0;

   line_tile_intersection_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic longint floor_tile(input longint v);
      if (v >= 0) return v >>> TB_TILE_BITS;
      return -(((-v) - 1) >>> TB_TILE_BITS) - 1;
   endfunction

   function automatic bit on_edge(input longint c, input longint t);
      return floor_tile(c) == t || floor_tile(c - 1) == t;
   endfunction

   function automatic crossing_type predict_crossing(input int px, input int py,
                                                     input int ddx, input int ddy);
      longint x, y, dx, dy, tu, tx, ty, ox, oy;
      longint enx, eny, exx, exy, ily, iry, itx, ibx, sx, sy, ax, ay, q, mx, my;
      bit hit, lt, rt, tt, bt, main_only, anti_only;
      crossing_type r;
      x = px; y = py; dx = ddx; dy = ddy; tu = TB_TILE_SIZE;
      tx = floor_tile(x); ty = floor_tile(y);
      ox = x - tx * tu; oy = y - ty * tu;
      enx = -4 * tu; eny = enx; exx = enx; exy = enx;
      ily = y - 4 * tu; iry = ily; itx = x - 4 * tu; ibx = itx;
      sx = 0; sy = 0; hit = 0;
      if (ox == 0 && dx < 0) begin tx--; ox = tu; end
      if (oy == 0 && dy < 0) begin ty--; oy = tu; end
      if (dx != 0) begin
         ily = y - (ox * dy) / dx;
         iry = y + ((tu - ox) * dy) / dx;
      end
      if (dy != 0) begin
         itx = x - (oy * dx) / dy;
         ibx = x + ((tu - oy) * dx) / dy;
      end
      if (on_edge(ily, ty)) begin
         if (dx >= 0) begin enx = tx * tu; eny = ily; end
         else begin exx = tx * tu; exy = ily; end
      end
      if (on_edge(iry, ty)) begin
         if (dx >= 0) begin exx = (tx + 1) * tu; exy = iry; end
         else begin enx = (tx + 1) * tu; eny = iry; end
      end
      if (on_edge(itx, tx)) begin
         if (dy >= 0) begin enx = itx; eny = ty * tu; end
         else begin exx = itx; exy = ty * tu; end
      end
      if (on_edge(ibx, tx)) begin
         if (dy >= 0) begin exx = ibx; exy = (ty + 1) * tu; end
         else begin enx = ibx; eny = (ty + 1) * tu; end
      end
      lt = floor_tile(ily) == ty; rt = floor_tile(iry) == ty;
      tt = floor_tile(itx) == tx; bt = floor_tile(ibx) == tx;
      main_only = (tt == lt) && (bt == rt);
      anti_only = !main_only && (bt == lt) && (tt == rt);
      // Only one diagonal crossing is ever reported, the anti-diagonal first.
      if (!main_only && dx + dy != 0) begin
         ax = tx * tu + (dx * (tu - oy) + dy * ox) / (dx + dy);
         ay = ty * tu + (dy * (tu - ox) + dx * oy) / (dx + dy);
         if (floor_tile(ax) == tx && floor_tile(ay) == ty) begin
            sx = ax; sy = ay; hit = 1;
         end
      end
      if (!hit && !anti_only && dx - dy != 0) begin
         q = (dx * oy - dy * ox) / (dx - dy);
         mx = tx * tu + q; my = ty * tu + q;
         if (floor_tile(mx) == tx && floor_tile(my) == ty) begin
            sx = mx; sy = my; hit = 1;
         end
      end
      r.entry_x = enx[16:0]; r.entry_y = eny[16:0];
      r.exit_x = exx[16:0]; r.exit_y = exy[16:0];
      r.split_x = sx[16:0]; r.split_y = sy[16:0];
      r.crosses = hit;
      return r;
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   bit stall_enable = 1'b0;

   // Result side: compare each accepted word with the oldest prediction; random back pressure once stall_enable is set.
   always @(posedge clock) begin
      crossing_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_crossings.size() == 0) begin
               $error("result word with nothing expected");
               error_count++;
            end else begin
               want = expected_crossings.pop_front();
               if (rsp_tdata[16:0] !== want.entry_x) begin
                  $error("entry_x expected %h got %h", want.entry_x, rsp_tdata[16:0]);
                  error_count++;
               end
               if (rsp_tdata[33:17] !== want.entry_y) begin
                  $error("entry_y expected %h got %h", want.entry_y, rsp_tdata[33:17]);
                  error_count++;
               end
               if (rsp_tdata[50:34] !== want.exit_x) begin
                  $error("exit_x expected %h got %h", want.exit_x, rsp_tdata[50:34]);
                  error_count++;
               end
               if (rsp_tdata[67:51] !== want.exit_y) begin
                  $error("exit_y expected %h got %h", want.exit_y, rsp_tdata[67:51]);
                  error_count++;
               end
               if (rsp_tdata[84:68] !== want.split_x) begin
                  $error("split_x expected %h got %h", want.split_x, rsp_tdata[84:68]);
                  error_count++;
               end
               if (rsp_tdata[101:85] !== want.split_y) begin
                  $error("split_y expected %h got %h", want.split_y, rsp_tdata[101:85]);
                  error_count++;
               end
               if (rsp_tuser[0] !== want.crosses) begin
                  $error("crosses_split expected %b got %b", want.crosses, rsp_tuser[0]);
                  error_count++;
               end
            end
         end
         if (!stall_enable) rsp_tready <= 1'b1;
         else if ($urandom_range(0, 15) == 0) rsp_tready <= 1'b0;
         else if ($urandom_range(0, 2) == 0) rsp_tready <= 1'b1;
      end
   end

   bit sender_gaps = 1'b1;

   // The valid line stays high between back-to-back words; idle phases drop it.
   task automatic send_line(input int px, input int py, input int ddx, input int ddy);
      int gap;
      logic [ltile_pkg::IN_DATA_W-1:0] word;
      gap = sender_gaps ? random_gap() : 0;
      word = '0;
      word[14:0] = px[14:0];
      word[29:15] = py[14:0];
      word[45:30] = ddx[15:0];
      word[61:46] = ddy[15:0];
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_crossings.push_back(predict_crossing(px, py, $signed(ddx[15:0]),
                                                    $signed(ddy[15:0])));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_crossings.size() != 0) @(posedge clock);
   endtask

   function automatic int random_dir();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $signed(16'($urandom_range(0, 65535)));
         2: return $urandom_range(0, 8) - 4;
         3: return $urandom_range(0, 64) - 32;
         4: return $urandom_range(0, 1) ? 32767 : -32768;
         default: return $urandom_range(0, 1024) - 512;
      endcase
   endfunction

   function automatic int random_point();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 255) * TB_TILE_SIZE;
         1: return $urandom_range(0, 1) ? $urandom_range(0, 3) : 32767 - $urandom_range(0, 3);
         default: return $urandom_range(0, 32767);
      endcase
   endfunction

   task automatic test_extremes();
      send_line(0, 0, 0, 0);
      send_line(0, 0, -1, -1);
      send_line(0, 0, -32768, -32768);
      send_line(32767, 32767, 32767, 32767);
      send_line(32767, 0, -32768, 32767);
      send_line(0, 32767, 32767, -32768);
      send_line(128, 256, -5, 3);
      send_line(128, 256, 7, -9);
   endtask

   task automatic test_special_cases();
      send_line(300, 400, 0, 5);       // vertical line
      send_line(300, 400, 5, 0);       // horizontal line
      send_line(300, 400, 3, 3);       // parallel to the main diagonal
      send_line(300, 400, 3, -3);      // parallel to the anti-diagonal
      send_line(256, 384, -2, -7);     // corner point, backward in both axes
      send_line(640, 200, -1, 0);      // backward step in x only
      send_line(200, 640, 0, -1);      // backward step in y only
      send_line(260, 260, 1, 1);
      send_line(330, 270, -17, 40);
      send_line(5000, 12345, 123, -4567);
   endtask

   task automatic test_random_lines(input int count);
      for (int i = 0; i < count; i++) begin
         sender_gaps = (i % 200) < 150;
         send_line(random_point(), random_point(), random_dir(), random_dir());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      stall_enable = 1'b1;
      test_special_cases();
      drain_results();
      test_random_lines(400);
      // Let the pipeline run dry before the second random batch.
      drain_results();
      test_random_lines(430);
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
